>>> rtl/glw_pkg.sv
package glw_pkg;

    // Column index saturates here (17-bit outputs).
    localparam int unsigned MAX_COLUMNS = 65536;
    localparam int unsigned COL_W       = 17;

    // Queue between front and back.
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 8'd1;

    localparam logic [15:0] LINE_HEIGHT_RESET = 16'd1024;

    typedef enum logic [1:0] {
        BRK_NONE = 2'd0,
        BRK_SOFT = 2'd1,
        BRK_HARD = 2'd2
    } glw_brk_t;

    typedef enum logic {
        CLS_TEXT    = 1'b0,
        CLS_NEWLINE = 1'b1
    } glw_class_t;

    typedef struct packed {
        logic [15:0] adv;
        glw_class_t  cls;
        logic [23:0] byte_lo;
        logic [23:0] byte_hi;
        logic [15:0] glyph_lo;
        logic [15:0] glyph_hi;
        logic        fin;
    } glw_item_t;

    typedef struct packed {
        logic [COL_W-1:0] col_start;
        logic [COL_W-1:0] col_end;
        logic [23:0]      byte_lo;
        logic [23:0]      byte_hi;
        logic [15:0]      glyph_lo;
        logic [15:0]      glyph_hi;
        logic [31:0]      top;
        logic [23:0]      span_width;
        glw_brk_t         kind;
        logic             last;
        logic [23:0]      widest;
        logic [31:0]      height;
    } glw_rec_t;

endpackage

>>> rtl/glw_front.sv
module glw_front
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [15:0]           advance,
    input  logic                  is_newline,
    input  logic [23:0]           span_byte_start,
    input  logic [23:0]           span_byte_end,
    input  logic [15:0]           span_glyph_start,
    input  logic [15:0]           span_glyph_end,
    input  logic                  final_column,
    input  logic                  q_full,
    output logic                  q_push,
    output glw_pkg::glw_item_t    q_item
);

    // Accept whenever the queue has room; tag each column as text or line feed.
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.adv      = advance;
        q_item.cls      = is_newline ? glw_pkg::CLS_NEWLINE : glw_pkg::CLS_TEXT;
        q_item.byte_lo  = span_byte_start;
        q_item.byte_hi  = span_byte_end;
        q_item.glyph_lo = span_glyph_start;
        q_item.glyph_hi = span_glyph_end;
        q_item.fin      = final_column;
    end

endmodule

>>> rtl/glw_queue.sv
module glw_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  glw_pkg::glw_item_t    push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output glw_pkg::glw_item_t    head_item
);

    glw_pkg::glw_item_t                 mem_reg [glw_pkg::QDEPTH];
    logic [glw_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [glw_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [glw_pkg::QCNT_W-1:0]         count_reg;
    logic [glw_pkg::QCNT_W-1:0]         count_next;

    assign full      = (count_reg == glw_pkg::QCNT_W'(glw_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/glw_back.sv
module glw_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [23:0]           wrap_width,
    input  logic [15:0]           row_pitch,
    input  logic                  q_not_empty,
    input  glw_pkg::glw_item_t    q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output glw_pkg::glw_rec_t     out_rec
);

    localparam logic [glw_pkg::COL_W-1:0] MAX_COL = glw_pkg::COL_W'(glw_pkg::MAX_COLUMNS);

    // Line state
    logic [glw_pkg::COL_W-1:0] col_count_reg;
    logic [glw_pkg::COL_W-1:0] line_start_reg;
    logic [23:0]               run_width_reg;
    logic [31:0]               top_reg;
    logic [23:0]               first_byte_reg;
    logic [15:0]               first_glyph_reg;
    logic [23:0]               prev_byte_reg;
    logic [15:0]               prev_glyph_reg;
    logic [23:0]               widest_reg;

    logic [glw_pkg::COL_W-1:0] col_next;
    logic [glw_pkg::COL_W-1:0] line_start_next;
    logic [23:0]               run_width_next;
    logic [31:0]               top_next;
    logic [23:0]               first_byte_next;
    logic [15:0]               first_glyph_next;
    logic [23:0]               widest_next;

    // Output register plus one pending record for items that close two lines
    logic                      out_valid_reg;
    glw_pkg::glw_rec_t         out_rec_reg;
    logic                      pend_valid_reg;
    glw_pkg::glw_rec_t         pend_rec_reg;

    logic                      is_nl;
    logic                      soft_brk;
    logic                      brk;
    logic                      empty_a;
    logic                      empty_f;
    logic                      starts_line;
    logic [24:0]               sum_w;
    logic [32:0]               top_p1;
    logic [33:0]               top_p2;
    logic [31:0]               top_sat1;
    logic [31:0]               top_sat2;
    logic [23:0]               widest_a;
    logic [23:0]               run_width_text;
    glw_pkg::glw_rec_t         rec_a;
    glw_pkg::glw_rec_t         rec_f;
    logic                      can_load;

    assign can_load  = !out_valid_reg || out_ready;
    assign q_pop     = q_not_empty && can_load && !pend_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

    always_comb
    begin
        is_nl    = (q_item.cls == glw_pkg::CLS_NEWLINE);
        col_next = (col_count_reg == MAX_COL) ? col_count_reg : col_count_reg + 1'b1;

        // exact sum for the fit test, saturated for the width
        sum_w    = {1'b0, run_width_reg} + {9'd0, q_item.adv};
        soft_brk = !is_nl && (wrap_width != '0) && (col_count_reg > line_start_reg)
                   && (sum_w > {1'b0, wrap_width});
        brk      = is_nl || soft_brk;

        // top + pitch and top + 2*pitch side by side
        top_p1   = {1'b0, top_reg} + {17'd0, row_pitch};
        top_p2   = {2'b0, top_reg} + {17'd0, row_pitch, 1'b0};
        top_sat1 = top_p1[32] ? '1 : top_p1[31:0];
        top_sat2 = (|top_p2[33:32]) ? '1 : top_p2[31:0];

        widest_a = (run_width_reg > widest_reg) ? run_width_reg : widest_reg;

        // record for the hard or soft break
        empty_a          = is_nl && (line_start_reg >= col_count_reg);
        rec_a.col_start  = line_start_reg;
        rec_a.col_end    = col_count_reg;
        rec_a.byte_lo    = empty_a ? q_item.byte_lo : first_byte_reg;
        rec_a.byte_hi    = empty_a ? q_item.byte_lo : prev_byte_reg;
        rec_a.glyph_lo   = empty_a ? q_item.glyph_lo : first_glyph_reg;
        rec_a.glyph_hi   = empty_a ? q_item.glyph_lo : prev_glyph_reg;
        rec_a.top        = top_reg;
        rec_a.span_width = run_width_reg;
        rec_a.kind       = is_nl ? glw_pkg::BRK_HARD : glw_pkg::BRK_SOFT;
        rec_a.last       = 1'b0;
        rec_a.widest     = widest_a;
        rec_a.height     = '0;

        // state after this column
        if (is_nl)
        begin
            line_start_next = col_next;
        end
        else if (soft_brk)
        begin
            line_start_next = col_count_reg;
        end
        else
        begin
            line_start_next = line_start_reg;
        end
        top_next    = brk ? top_sat1 : top_reg;
        widest_next = brk ? widest_a : widest_reg;

        run_width_text = soft_brk ? {8'd0, q_item.adv} : (sum_w[24] ? '1 : sum_w[23:0]);
        run_width_next = is_nl ? '0 : run_width_text;

        starts_line      = !is_nl && (soft_brk || (col_count_reg == line_start_reg));
        first_byte_next  = starts_line ? q_item.byte_lo : first_byte_reg;
        first_glyph_next = starts_line ? q_item.glyph_lo : first_glyph_reg;

        // closing line on the final column
        empty_f          = (line_start_next >= col_next);
        rec_f.col_start  = line_start_next;
        rec_f.col_end    = col_next;
        rec_f.byte_lo    = empty_f ? q_item.byte_hi : first_byte_next;
        rec_f.byte_hi    = q_item.byte_hi;
        rec_f.glyph_lo   = empty_f ? q_item.glyph_hi : first_glyph_next;
        rec_f.glyph_hi   = q_item.glyph_hi;
        rec_f.top        = top_next;
        rec_f.span_width = run_width_next;
        rec_f.kind       = glw_pkg::BRK_NONE;
        rec_f.last       = 1'b1;
        rec_f.widest     = (run_width_next > widest_next) ? run_width_next : widest_next;
        rec_f.height     = brk ? top_sat2 : top_sat1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg   <= '0;
            line_start_reg  <= '0;
            run_width_reg   <= '0;
            top_reg         <= '0;
            first_byte_reg  <= '0;
            first_glyph_reg <= '0;
            prev_byte_reg   <= '0;
            prev_glyph_reg  <= '0;
            widest_reg      <= '0;
        end
        else if (q_pop)
        begin
            if (q_item.fin)
            begin
                col_count_reg   <= '0;
                line_start_reg  <= '0;
                run_width_reg   <= '0;
                top_reg         <= '0;
                first_byte_reg  <= '0;
                first_glyph_reg <= '0;
                prev_byte_reg   <= '0;
                prev_glyph_reg  <= '0;
                widest_reg      <= '0;
            end
            else
            begin
                col_count_reg   <= col_next;
                line_start_reg  <= line_start_next;
                run_width_reg   <= run_width_next;
                top_reg         <= top_next;
                first_byte_reg  <= first_byte_next;
                first_glyph_reg <= first_glyph_next;
                prev_byte_reg   <= q_item.byte_hi;
                prev_glyph_reg  <= q_item.glyph_hi;
                widest_reg      <= widest_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (q_pop)
            begin
                out_valid_reg  <= brk || q_item.fin;
                pend_valid_reg <= brk && q_item.fin;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            if (pend_valid_reg)
            begin
                out_rec_reg <= pend_rec_reg;
            end
            else if (q_pop)
            begin
                out_rec_reg <= brk ? rec_a : rec_f;
            end
        end
        if (q_pop && brk && q_item.fin)
        begin
            pend_rec_reg <= rec_f;
        end
    end

endmodule

>>> rtl/greedy_line_wrap.sv
// Channel  Handshake              Payload
// -------  ---------------------  -------------------------------------------------
// in       in_valid / in_ready    advance, is_newline, span_*, final_column
// out      out_valid / out_ready  line_* ranges, line_top, line_kind, last_line, ...
// cfg      cfg_valid / cfg_ready  cfg_index (0 wrap width, 1 row pitch), cfg_data
//
// Takes one column per cycle while the queue has room; each column is stored in the queue, and its record is
// then registered in the output register. A column that both breaks a line and ends the text yields two records;
// the second waits in a pending register, and the back end takes no column until it has gone to the output.
// Four-entry queue lets input and output stall independently.
// rst_n clears line state and config (wrap width 0, row pitch 1024).
// cfg_ready is always high; unknown indexes are dropped.
module greedy_line_wrap
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] advance,
    input  logic        is_newline,
    input  logic [23:0] span_byte_start,
    input  logic [23:0] span_byte_end,
    input  logic [15:0] span_glyph_start,
    input  logic [15:0] span_glyph_end,
    input  logic        final_column,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] line_col_start,
    output logic [16:0] line_col_end,
    output logic [23:0] line_byte_start,
    output logic [23:0] line_byte_end,
    output logic [15:0] line_glyph_start,
    output logic [15:0] line_glyph_end,
    output logic [31:0] line_top,
    output logic [23:0] line_span_width,
    output logic [1:0]  line_kind,
    output logic        last_line,
    output logic [23:0] widest_so_far,
    output logic [31:0] total_height,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    // config registers
    logic [23:0]        wrap_width_reg;
    logic [15:0]        line_height_reg;

    // front -> queue -> back
    logic               q_full;
    logic               q_push;
    glw_pkg::glw_item_t q_in_item;
    logic               q_pop;
    logic               q_not_empty;
    glw_pkg::glw_item_t q_head_item;
    glw_pkg::glw_rec_t  rec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_width_reg  <= '0;
            line_height_reg <= glw_pkg::LINE_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                glw_pkg::CFG_WRAP_WIDTH:  wrap_width_reg  <= cfg_data;
                glw_pkg::CFG_LINE_HEIGHT: line_height_reg <= cfg_data[15:0];
                default:                  ;
            endcase
        end
    end

    glw_front u_front
    (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .advance          (advance),
        .is_newline       (is_newline),
        .span_byte_start  (span_byte_start),
        .span_byte_end    (span_byte_end),
        .span_glyph_start (span_glyph_start),
        .span_glyph_end   (span_glyph_end),
        .final_column     (final_column),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (q_in_item)
    );

    glw_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head_item)
    );

    // back end: line state, break decision, output register
    glw_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .wrap_width  (wrap_width_reg),
        .row_pitch   (line_height_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_head_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_rec     (rec)
    );

    assign line_col_start   = rec.col_start;
    assign line_col_end     = rec.col_end;
    assign line_byte_start  = rec.byte_lo;
    assign line_byte_end    = rec.byte_hi;
    assign line_glyph_start = rec.glyph_lo;
    assign line_glyph_end   = rec.glyph_hi;
    assign line_top         = rec.top;
    assign line_span_width  = rec.span_width;
    assign line_kind        = rec.kind;
    assign last_line        = rec.last;
    assign widest_so_far    = rec.widest;
    assign total_height     = rec.height;

endmodule

>>> tb/greedy_line_wrap_test.sv
`timescale 1ns / 100ps

// Line wrapper testbench: columns go in as requests, line records come out and
// are checked field by field against an in-bench line-breaking predictor.
module greedy_line_wrap_test;

    // An index that decodes to no register; the block drops such writes.
    localparam logic [glw_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hFF;

    localparam int          WATCHDOG_CYCLES = 2000;
    // Margin for results to pass the queue, the output register and a pending double record.
    localparam int          SETTLE_CYCLES   = 8;
    localparam logic [23:0] MAX24           = 24'hFFFFFF;
    localparam logic [31:0] MAX32           = 32'hFFFFFFFF;

    logic        clk;
    logic        rst_n            = 1'b0;

    logic        in_valid         = 1'b0;
    logic        in_ready;
    logic [15:0] advance          = '0;
    logic        is_newline       = 1'b0;
    logic [23:0] span_byte_start  = '0;
    logic [23:0] span_byte_end    = '0;
    logic [15:0] span_glyph_start = '0;
    logic [15:0] span_glyph_end   = '0;
    logic        final_column     = 1'b0;

    logic        out_valid;
    logic        out_ready        = 1'b0;
    logic [16:0] line_col_start;
    logic [16:0] line_col_end;
    logic [23:0] line_byte_start;
    logic [23:0] line_byte_end;
    logic [15:0] line_glyph_start;
    logic [15:0] line_glyph_end;
    logic [31:0] line_top;
    logic [23:0] line_span_width;
    logic [1:0]  line_kind;
    logic        last_line;
    logic [23:0] widest_so_far;
    logic [31:0] total_height;

    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index        = '0;
    logic [23:0] cfg_data         = '0;

    greedy_line_wrap dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .advance          (advance),
        .is_newline       (is_newline),
        .span_byte_start  (span_byte_start),
        .span_byte_end    (span_byte_end),
        .span_glyph_start (span_glyph_start),
        .span_glyph_end   (span_glyph_end),
        .final_column     (final_column),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .line_col_start   (line_col_start),
        .line_col_end     (line_col_end),
        .line_byte_start  (line_byte_start),
        .line_byte_end    (line_byte_end),
        .line_glyph_start (line_glyph_start),
        .line_glyph_end   (line_glyph_end),
        .line_top         (line_top),
        .line_span_width  (line_span_width),
        .line_kind        (line_kind),
        .last_line        (last_line),
        .widest_so_far    (widest_so_far),
        .total_height     (total_height),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Percent of cycles each side holds off; dropped to zero for the long test.
    int unsigned in_idle_pct  = 25;
    int unsigned out_idle_pct = 25;
    int unsigned fail_count   = 0;
    int unsigned column_reqs  = 0;
    int unsigned stuck_cycles = 0;

    // ------------------------------------------------------------------
    // Wrapper predictor: register copies and per-text line state.
    // ------------------------------------------------------------------
    logic [23:0] wrap_w;
    logic [15:0] line_h;

    int unsigned col_seen;       // columns taken in this text, saturates
    int unsigned line_col0;      // first column of the open line
    logic [23:0] line_w;         // advances summed on the open line
    logic [31:0] line_y;         // top of the open line
    logic [23:0] line_byte0;
    logic [15:0] line_glyph0;
    logic [23:0] prev_byte_end;
    logic [15:0] prev_glyph_end;
    logic [23:0] widest_w;

    // Line records still owed by the block, oldest first.
    glw_pkg::glw_rec_t owed_lines[$];

    function automatic logic [31:0] add_sat32(logic [31:0] a, logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? MAX32 : s[31:0];
    endfunction

    function automatic logic [23:0] add_sat24(logic [23:0] a, logic [15:0] b);
        logic [24:0] s;
        s = {1'b0, a} + 25'(b);
        return s[24] ? MAX24 : s[23:0];
    endfunction

    function automatic void clear_text();
        col_seen       = 0;
        line_col0      = 0;
        line_w         = '0;
        line_y         = '0;
        line_byte0     = '0;
        line_glyph0    = '0;
        prev_byte_end  = '0;
        prev_glyph_end = '0;
        widest_w       = '0;
    endfunction

    // Record for the open line; width and top come from the current state.
    function automatic void owe_line(int unsigned cs, int unsigned ce,
                                     logic [23:0] bs, logic [23:0] be,
                                     logic [15:0] gs, logic [15:0] ge,
                                     glw_pkg::glw_brk_t kind, logic last,
                                     logic [31:0] height);
        glw_pkg::glw_rec_t r;
        if (line_w > widest_w)
            widest_w = line_w;
        r.col_start  = cs[glw_pkg::COL_W-1:0];
        r.col_end    = ce[glw_pkg::COL_W-1:0];
        r.byte_lo    = bs;
        r.byte_hi    = be;
        r.glyph_lo   = gs;
        r.glyph_hi   = ge;
        r.top        = line_y;
        r.span_width = line_w;
        r.kind       = kind;
        r.last       = last;
        r.widest     = widest_w;
        r.height     = height;
        owed_lines   = {owed_lines, r};
    endfunction

    // Greedy first-fit step for one accepted column.
    function automatic void wrap_column(glw_pkg::glw_item_t c);
        int unsigned idx;
        int unsigned nxt;
        logic        empty;
        idx = (col_seen > glw_pkg::MAX_COLUMNS) ? glw_pkg::MAX_COLUMNS : col_seen;
        nxt = (idx + 1 > glw_pkg::MAX_COLUMNS) ? glw_pkg::MAX_COLUMNS : idx + 1;
        if (c.cls == glw_pkg::CLS_NEWLINE)
        begin
            // The line feed itself belongs to no line; an empty line sits
            // at the line feed's own start.
            empty = (line_col0 >= idx);
            owe_line(line_col0, idx,
                     empty ? c.byte_lo : line_byte0,
                     empty ? c.byte_lo : prev_byte_end,
                     empty ? c.glyph_lo : line_glyph0,
                     empty ? c.glyph_lo : prev_glyph_end,
                     glw_pkg::BRK_HARD, 1'b0, '0);
            line_y    = add_sat32(line_y, line_h);
            line_col0 = nxt;
            line_w    = '0;
        end
        else
        begin
            // Soft break uses the exact sum, not the saturated width.
            if (wrap_w != '0 && idx > line_col0 &&
                25'(line_w) + 25'(c.adv) > 25'(wrap_w))
            begin
                owe_line(line_col0, idx, line_byte0, prev_byte_end,
                         line_glyph0, prev_glyph_end, glw_pkg::BRK_SOFT, 1'b0, '0);
                line_y    = add_sat32(line_y, line_h);
                line_col0 = idx;
                line_w    = '0;
            end
            if (idx == line_col0)
            begin
                line_byte0  = c.byte_lo;
                line_glyph0 = c.glyph_lo;
            end
            line_w = add_sat24(line_w, c.adv);
        end
        prev_byte_end  = c.byte_hi;
        prev_glyph_end = c.glyph_hi;
        col_seen       = nxt;
        if (c.fin)
        begin
            // Closing line; a trailing empty line sits at the last column's ends.
            empty = (line_col0 >= col_seen);
            owe_line(line_col0, col_seen,
                     empty ? c.byte_hi : line_byte0, c.byte_hi,
                     empty ? c.glyph_hi : line_glyph0, c.glyph_hi,
                     glw_pkg::BRK_NONE, 1'b1, add_sat32(line_y, line_h));
            clear_text();
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure, compare against the oldest owed line.
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_idle_pct);

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : line_check
        glw_pkg::glw_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_lines.size() == 0)
            begin
                fail_count++;
                $error("line record with nothing owed: col %0d..%0d kind %0d",
                       line_col_start, line_col_end, line_kind);
            end
            else
            begin
                want = owed_lines.pop_front();
                check_field("line_col_start",   32'(want.col_start),  32'(line_col_start));
                check_field("line_col_end",     32'(want.col_end),    32'(line_col_end));
                check_field("line_byte_start",  32'(want.byte_lo),    32'(line_byte_start));
                check_field("line_byte_end",    32'(want.byte_hi),    32'(line_byte_end));
                check_field("line_glyph_start", 32'(want.glyph_lo),   32'(line_glyph_start));
                check_field("line_glyph_end",   32'(want.glyph_hi),   32'(line_glyph_end));
                check_field("line_top",         want.top,             line_top);
                check_field("line_span_width",  32'(want.span_width), 32'(line_span_width));
                check_field("line_kind",        32'(want.kind),       32'(line_kind));
                check_field("last_line",        32'(want.last),       32'(last_line));
                check_field("widest_so_far",    32'(want.widest),     32'(widest_so_far));
                check_field("total_height",     want.height,          total_height);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side. All tasks are entered and left at a falling edge.
    // ------------------------------------------------------------------
    function automatic glw_pkg::glw_item_t make_column(logic [15:0] adv,
                                                       glw_pkg::glw_class_t cls,
                                                       logic [23:0] bs, logic [23:0] be,
                                                       logic [15:0] gs, logic [15:0] ge,
                                                       logic fin);
        glw_pkg::glw_item_t c;
        c.adv      = adv;
        c.cls      = cls;
        c.byte_lo  = bs;
        c.byte_hi  = be;
        c.glyph_lo = gs;
        c.glyph_hi = ge;
        c.fin      = fin;
        return c;
    endfunction

    // One column request; valid stays up until taken, then prediction runs.
    task automatic send_column(input glw_pkg::glw_item_t c);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid         = 1'b1;
        advance          = c.adv;
        is_newline       = c.cls;
        span_byte_start  = c.byte_lo;
        span_byte_end    = c.byte_hi;
        span_glyph_start = c.glyph_lo;
        span_glyph_end   = c.glyph_hi;
        final_column     = c.fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        wrap_column(c);
        column_reqs++;
        @(negedge clk);
    endtask

    // Sender holds off until every owed line is out, then lets the pipe settle
    // since a column with no line may still be in flight.
    task automatic drain_lines();
        in_valid = 1'b0;
        while (owed_lines.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [glw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] data);
        drain_lines();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == glw_pkg::CFG_WRAP_WIDTH)
            wrap_w = data;
        else if (idx == glw_pkg::CFG_LINE_HEIGHT)
            line_h = data[15:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random text: mostly well-formed back-to-back spans, some noise columns
    // with arbitrary spans, plus some arbitrary advances. Optionally stalls halfway through.
    task automatic send_text(input int n_cols, input int nl_pct, input int adv_max,
                             input int noise_pct, input bit pause_mid);
        glw_pkg::glw_item_t c;
        logic [23:0]        byte_at;
        logic [15:0]        glyph_at;
        byte_at  = 24'($urandom);
        glyph_at = 16'($urandom);
        for (int i = 0; i < n_cols; i++)
        begin
            c.adv = ($urandom_range(99) < 5) ? 16'($urandom)
                                             : 16'($urandom_range(0, adv_max));
            c.cls = ($urandom_range(99) < nl_pct) ? glw_pkg::CLS_NEWLINE
                                                  : glw_pkg::CLS_TEXT;
            c.byte_lo  = byte_at;
            c.byte_hi  = byte_at + 24'($urandom_range(1, 4));
            c.glyph_lo = glyph_at;
            c.glyph_hi = glyph_at + 16'($urandom_range(0, 2));
            if ($urandom_range(99) < noise_pct)
            begin
                c.byte_lo  = 24'($urandom);
                c.byte_hi  = 24'($urandom);
                c.glyph_lo = 16'($urandom);
                c.glyph_hi = 16'($urandom);
            end
            c.fin = (i == n_cols - 1);
            if (pause_mid && i == n_cols / 2)
                drain_lines();
            send_column(c);
            byte_at  = c.byte_hi;
            glyph_at = c.glyph_hi;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Single-column texts at field extremes, reversed spans, lone line feed.
    task automatic test_single_columns();
        send_column(make_column(16'hFFFF, glw_pkg::CLS_TEXT, 24'h000000, MAX24,
                                16'h0000, 16'hFFFF, 1'b1));
        send_column(make_column(16'h0000, glw_pkg::CLS_TEXT, MAX24, 24'h000000,
                                16'hFFFF, 16'h0000, 1'b1));
        // Line feed as whole text: empty hard line then empty closing line.
        send_column(make_column(16'h1234, glw_pkg::CLS_NEWLINE, 24'h00000A, 24'h00000B,
                                16'h0005, 16'h0006, 1'b1));
    endtask

    // "ab", empty hard line, "c", text ending on a line feed.
    task automatic test_hard_breaks();
        send_column(make_column(16'd100, glw_pkg::CLS_TEXT,
                                24'd10, 24'd11, 16'd4, 16'd5, 1'b0));
        send_column(make_column(16'd200, glw_pkg::CLS_TEXT,
                                24'd11, 24'd13, 16'd5, 16'd7, 1'b0));
        send_column(make_column(16'd999, glw_pkg::CLS_NEWLINE,
                                24'd13, 24'd14, 16'd7, 16'd8, 1'b0));
        send_column(make_column(16'd0,   glw_pkg::CLS_NEWLINE,
                                24'd14, 24'd15, 16'd8, 16'd9, 1'b0));
        send_column(make_column(16'd50,  glw_pkg::CLS_TEXT,
                                24'd15, 24'd16, 16'd9, 16'd9, 1'b0));
        send_column(make_column(16'd7,   glw_pkg::CLS_NEWLINE,
                                24'd16, 24'd17, 16'd9, 16'd10, 1'b1));
    endtask

    task automatic test_soft_wrap();
        write_reg(glw_pkg::CFG_WRAP_WIDTH, 24'd100);
        write_reg(glw_pkg::CFG_LINE_HEIGHT, 24'd0);
        // Second column breaks; an overwide first column stays on its line;
        // the final column both breaks and closes, giving two records.
        send_column(make_column(16'd60,  glw_pkg::CLS_TEXT,
                                24'd0, 24'd1, 16'd0, 16'd1, 1'b0));
        send_column(make_column(16'd60,  glw_pkg::CLS_TEXT,
                                24'd1, 24'd2, 16'd1, 16'd2, 1'b0));
        send_column(make_column(16'd150, glw_pkg::CLS_TEXT,
                                24'd2, 24'd3, 16'd2, 16'd3, 1'b0));
        send_column(make_column(16'd40,  glw_pkg::CLS_TEXT,
                                24'd3, 24'd4, 16'd3, 16'd4, 1'b0));
        send_column(make_column(16'd100, glw_pkg::CLS_TEXT,
                                24'd4, 24'd5, 16'd4, 16'd5, 1'b1));
        // Unknown register index must not disturb anything.
        write_reg(CFG_IDX_UNUSED, 24'h5A5A5A);
        write_reg(glw_pkg::CFG_WRAP_WIDTH, 24'd1);
        send_column(make_column(16'd0, glw_pkg::CLS_TEXT,
                                24'd8,  24'd9,  16'd8,  16'd9,  1'b0));
        send_column(make_column(16'd0, glw_pkg::CLS_TEXT,
                                24'd9,  24'd10, 16'd9,  16'd10, 1'b0));
        send_column(make_column(16'd1, glw_pkg::CLS_TEXT,
                                24'd10, 24'd11, 16'd10, 16'd11, 1'b0));
        send_column(make_column(16'd1, glw_pkg::CLS_TEXT,
                                24'd11, 24'd12, 16'd11, 16'd12, 1'b1));
    endtask

    // Line width past 24 bits: a maximal wrap width breaks on the exact sum,
    // and with wrapping off the width saturates.
    task automatic test_width_saturation();
        logic [23:0] b;
        in_idle_pct  = 0;
        out_idle_pct = 0;
        write_reg(glw_pkg::CFG_WRAP_WIDTH, MAX24);
        write_reg(glw_pkg::CFG_LINE_HEIGHT, 24'h00FFFF);
        for (int pass = 0; pass < 2; pass++)
        begin
            b = 24'h100 * 24'(pass);
            for (int i = 0; i < 258; i++)
                send_column(make_column(16'hFFFF, glw_pkg::CLS_TEXT,
                                        b + 24'(i), b + 24'(i + 1),
                                        16'(i), 16'(i + 1), i == 257));
            write_reg(glw_pkg::CFG_WRAP_WIDTH, '0);
        end
        in_idle_pct  = 25;
        out_idle_pct = 25;
    endtask

    // Random texts across several register settings, extremes included.
    task automatic test_random_texts();
        logic [23:0] wraps [6];
        logic [23:0] heights [6];
        int unsigned phase_start;
        wraps   = '{24'd0, 24'd800, 24'd1, MAX24, 24'($urandom_range(200, 3000)), 24'd3000};
        heights = '{24'd1024, 24'd64, 24'd0, 24'h00FFFF, 24'($urandom_range(0, 65535)), 24'd1};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(glw_pkg::CFG_WRAP_WIDTH, wraps[p]);
            write_reg(glw_pkg::CFG_LINE_HEIGHT, heights[p]);
            phase_start = column_reqs;
            while (column_reqs - phase_start < 10)
                send_text($urandom_range(1, 16), 12, 800, 8,
                          p == 1 && column_reqs == phase_start);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        wrap_w = '0;
        line_h = glw_pkg::LINE_HEIGHT_RESET;
        clear_text();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_columns();
        test_hard_breaks();
        test_soft_wrap();
        test_width_saturation();
        test_random_texts();

        drain_lines();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
